// File: rtl/dpf_pkg.sv
// Shared types and constants for the distinct prime factor emitter.
// No dependencies; imported by the controller top level.
`timescale 1ns / 1ps

package dpf_pkg;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_WAIT,
        ST_CHECK,
        ST_PUSH,
        ST_FIN,
        ST_EMIT_MID,
        ST_EMIT_LAST
    } dpf_state_t;

    // Candidate phase: testing a new divisor, or dividing a found one out
    typedef enum logic {
        MODE_FRESH,
        MODE_DIVOUT
    } dpf_mode_t;

    localparam int unsigned COUNT_W = 4;
    // Most primes reported for one item
    localparam logic [COUNT_W-1:0] MAX_RESULTS = 4'd9;
    // First trial divisor
    localparam int unsigned FIRST_CAND = 2;

endpackage

// File: rtl/distinct_prime_factor_emitter_top.sv
// Top level of the distinct prime factor emitter: trial-division controller,
// pending-result buffer and output register. Uses dpf_pkg and dpf_div.
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+-------------------------------
//  in      | in_valid / in_ready   | value
//  out     | out_valid / out_ready | prime, no_factor, last
//
// One item at a time. Every trial division runs through the bit-serial
// divider, launched in ST_LAUNCH and checked in ST_CHECK. An item runs one
// division for each candidate tried (up to the square root of the value)
// and one for each repeated division out of a prime power. Inputs of 0 or 1
// need no division and go straight to their single no-factor result.
// Reset clears all control state; no clearing pass. A stalled output only
// delays the controller when it has a further result to hand over.
`timescale 1ns / 1ps

module distinct_prime_factor_emitter_top #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VALUE_WIDTH-1:0] prime,
    output logic                   no_factor,
    output logic                   last
);

    import dpf_pkg::*;

    dpf_state_t             state_reg, state_next;
    dpf_mode_t              mode_reg, mode_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [VALUE_WIDTH-1:0] pend_reg, pend_next;
    logic                   nof_reg, nof_next;
    logic [VALUE_WIDTH-1:0] rest_reg, rest_next;
    logic [VALUE_WIDTH-1:0] cand_reg, cand_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] out_prime_reg, out_prime_next;
    logic                   out_nof_reg, out_nof_next;
    logic                   out_last_reg, out_last_next;

    logic                   div_start;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quot;
    logic [VALUE_WIDTH-1:0] div_rem;
    logic                   out_free;
    logic                   out_load;
    logic                   out_last_sel;
    logic                   accept;
    logic                   trivial;
    logic                   rem_zero;
    logic                   past_root;
    logic                   room;

    assign out_free  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign trivial   = (value <= VALUE_WIDTH'(1));
    assign rem_zero  = (div_rem == '0);
    assign past_root = (cand_reg > div_quot);
    assign room      = (count_reg < MAX_RESULTS);

    dpf_div #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rest_reg),
        .divisor  (cand_reg),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = trivial ? ST_EMIT_LAST : ST_LAUNCH;
            ST_LAUNCH:
                state_next = ST_WAIT;
            ST_WAIT:
                if (div_done)
                    state_next = ST_CHECK;
            ST_CHECK:
                if (mode_reg == MODE_FRESH && past_root)
                    state_next = ST_FIN;
                else if (mode_reg == MODE_FRESH && rem_zero && room && pend_valid_reg)
                    state_next = ST_PUSH;
                else
                    state_next = ST_LAUNCH;
            ST_PUSH:
                if (out_free)
                    state_next = ST_LAUNCH;
            ST_FIN:
                if (rest_reg != VALUE_WIDTH'(1) && room && pend_valid_reg)
                    state_next = ST_EMIT_MID;
                else
                    state_next = ST_EMIT_LAST;
            ST_EMIT_MID:
                if (out_free)
                    state_next = ST_EMIT_LAST;
            ST_EMIT_LAST:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_ready     = 1'b0;
        div_start    = 1'b0;
        out_load     = 1'b0;
        out_last_sel = 1'b0;
        unique case (state_reg)
            ST_IDLE:      in_ready = 1'b1;
            ST_LAUNCH:    div_start = 1'b1;
            ST_PUSH:      out_load = out_free;
            ST_EMIT_MID:  out_load = out_free;
            ST_EMIT_LAST:
            begin
                out_load     = out_free;
                out_last_sel = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Datapath updates
    always_comb
    begin
        mode_next       = mode_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        nof_next        = nof_reg;
        rest_next       = rest_reg;
        cand_next       = cand_reg;

        // New item
        if (accept)
        begin
            rest_next       = value;
            cand_next       = VALUE_WIDTH'(FIRST_CAND);
            mode_next       = MODE_FRESH;
            count_next      = '0;
            pend_valid_next = 1'b0;
            pend_next       = '0;
            nof_next        = trivial;
        end

        // Act on a finished trial division
        if (state_reg == ST_CHECK)
        begin
            if (mode_reg == MODE_FRESH)
            begin
                if (!past_root && !rem_zero)
                    cand_next = cand_reg + 1'b1;
                else if (!past_root)
                begin
                    rest_next = div_quot;
                    mode_next = MODE_DIVOUT;
                    if (room)
                    begin
                        count_next = count_reg + 1'b1;
                        if (!pend_valid_reg)
                        begin
                            pend_next       = cand_reg;
                            pend_valid_next = 1'b1;
                        end
                    end
                end
            end
            else if (rem_zero)
                rest_next = div_quot;
            else
            begin
                cand_next = cand_reg + 1'b1;
                mode_next = MODE_FRESH;
            end
        end

        // Older prime went out, newly found one waits
        if (state_reg == ST_PUSH && out_free)
            pend_next = cand_reg;

        // Leftover cofactor above one is the largest prime
        if (state_reg == ST_FIN && rest_reg != VALUE_WIDTH'(1) && room && !pend_valid_reg)
        begin
            pend_next       = rest_reg;
            pend_valid_next = 1'b1;
            count_next      = count_reg + 1'b1;
        end
        if (state_reg == ST_EMIT_MID && out_free)
        begin
            pend_next  = rest_reg;
            count_next = count_reg + 1'b1;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_prime_next = out_prime_reg;
        out_nof_next   = out_nof_reg;
        out_last_next  = out_last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_prime_next = pend_reg;
            out_nof_next   = nof_reg;
            out_last_next  = out_last_sel;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_FRESH;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_reg      <= pend_next;
        nof_reg       <= nof_next;
        rest_reg      <= rest_next;
        cand_reg      <= cand_next;
        out_prime_reg <= out_prime_next;
        out_nof_reg   <= out_nof_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign prime     = out_prime_reg;
    assign no_factor = out_nof_reg;
    assign last      = out_last_reg;

endmodule

// File: rtl/dpf_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Standalone; instantiated by distinct_prime_factor_emitter_top.
`timescale 1ns / 1ps

module dpf_div #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] quot,
    output logic [VALUE_WIDTH-1:0] rem
);

    localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] part_reg, part_next;
    logic [VALUE_WIDTH-1:0] shf_reg, shf_next;
    logic [VALUE_WIDTH-1:0] dsr_reg, dsr_next;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;
    logic                   ge;

    // One restoring step: bring down the next dividend bit, try the subtract
    assign trial = {part_reg, shf_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        part_next = part_reg;
        shf_next  = shf_reg;
        dsr_next  = dsr_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(VALUE_WIDTH);
            part_next = '0;
            shf_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            part_next = ge ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
            shf_next  = {shf_reg[VALUE_WIDTH-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
        shf_reg  <= shf_next;
        dsr_reg  <= dsr_next;
    end

    assign done = done_reg;
    assign quot = shf_reg;
    assign rem  = part_reg;

endmodule

// File: rtl/dpf_checker.sv
// Port-level checks for the distinct prime factor emitter, bound to the top.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module dpf_port_checks #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [VALUE_WIDTH-1:0] prime,
    input logic                   no_factor,
    input logic                   last
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(prime) && $stable(last)
            && $stable(no_factor))
        else $error("result changed while stalled");

    // The no-factor result is a lone item with a zero prime
    a_nof_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_factor |-> last && (prime == '0))
        else $error("malformed no-factor result");

    // A reported prime is at least two
    a_prime_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !no_factor |-> (prime > VALUE_WIDTH'(1)))
        else $error("prime below two");

    // Only the final result of an item may wait while a new item is taken
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> last)
        else $error("new item taken before results finished");

    // One item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken back to back");

endmodule

bind distinct_prime_factor_emitter_top dpf_port_checks #(
    .VALUE_WIDTH(VALUE_WIDTH)
) u_dpf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .prime     (prime),
    .no_factor (no_factor),
    .last      (last)
);

// File: bench/dpf_checker.sv
// Result checker for the distinct prime factor emitter: watches both channels,
// predicts the prime list of every accepted item and compares it in order.
// Depends on dpf_pkg for the result cap and the first trial divisor.
`timescale 1ns / 1ps

module dpf_checker #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [VALUE_WIDTH-1:0] prime,
    input  logic                   no_factor,
    input  logic                   last,
    output int                     fail_count,
    output int                     pending,
    output int                     values_seen,
    output int                     results_seen
);
    import dpf_pkg::*;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] prime;
        logic                   no_factor;
        logic                   is_last;
    } factor_rec_t;

    // Primes still owed by the block, oldest first
    factor_rec_t owed_factors[$];

    int mismatch_count = 0;
    int value_count    = 0;
    int result_count   = 0;
    int owed_count     = 0;

    assign fail_count   = mismatch_count;
    assign pending      = owed_count;
    assign values_seen  = value_count;
    assign results_seen = result_count;

    // Distinct primes of v in ascending order, capped, last one flagged
    function automatic void predict_factors(input logic [VALUE_WIDTH-1:0] v);
        longint unsigned rest;
        longint unsigned cand;
        longint unsigned found[$];
        factor_rec_t     rec;
        rest = v;
        if (rest <= 1)
        begin
            // zero and one: no prime at all
            rec.prime     = '0;
            rec.no_factor = 1'b1;
            rec.is_last   = 1'b1;
            owed_factors.insert(owed_factors.size(), rec);
            return;
        end
        for (cand = FIRST_CAND; cand <= rest / cand; cand++)
        begin
            if (rest % cand == 0)
            begin
                while (rest % cand == 0)
                    rest = rest / cand;
                found.insert(found.size(), cand);
            end
        end
        // leftover above one is a prime beyond the square-root bound
        if (rest != 1)
            found.insert(found.size(), rest);
        while (found.size() > int'(MAX_RESULTS))
            void'(found.pop_back());
        foreach (found[i])
        begin
            rec.prime     = VALUE_WIDTH'(found[i]);
            rec.no_factor = 1'b0;
            rec.is_last   = (i == found.size() - 1);
            owed_factors.insert(owed_factors.size(), rec);
        end
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Sample both channels at each edge
    always @(posedge clk)
    begin : watch
        factor_rec_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_factors(value);
                value_count++;
            end
            if (out_valid && out_ready)
            begin
                result_count++;
                if (owed_factors.size() == 0)
                begin
                    note_mismatch($sformatf(
                        "result with no item owed: prime=%0d no_factor=%0b last=%0b",
                        prime, no_factor, last));
                end
                else
                begin
                    want = owed_factors.pop_front();
                    if (prime !== want.prime || no_factor !== want.no_factor ||
                        last !== want.is_last)
                    begin
                        note_mismatch($sformatf(
                            "expected prime=%0d nof=%0b last=%0b, got prime=%0d nof=%0b last=%0b",
                            want.prime, want.no_factor, want.is_last, prime, no_factor, last));
                    end
                end
            end
            owed_count = owed_factors.size();
        end
    end

endmodule

// File: bench/tb_distinct_prime_factor_emitter_top.sv
// Top of the distinct prime factor emitter bench: clock, reset, item stimulus,
// output back-pressure, watchdog and verdict. Depends on the RTL top level,
// dpf_pkg and dpf_checker.
`timescale 1ns / 1ps

module tb_distinct_prime_factor_emitter_top;

    localparam int unsigned VW           = 32;
    localparam int unsigned STALL_LIMIT  = 300000;
    localparam int unsigned CHOKE_CYCLES = 4000;
    localparam int unsigned DRAIN_CYCLES = 100;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    logic [VW-1:0] value;
    logic          out_valid;
    logic          out_ready;
    logic [VW-1:0] prime;
    logic          no_factor;
    logic          last;

    int fail_count;
    int pending;
    int values_seen;
    int results_seen;

    int   tx_gap_pct;
    int   rx_gap_pct;
    logic choke_req;
    int   hold_left   = 0;
    bit   choke_taken = 1'b0;
    int   quiet_cycles = 0;

    longint unsigned small_primes[$];
    logic [VW-1:0]   edge_vals[$];

    distinct_prime_factor_emitter_top #(
        .VALUE_WIDTH (VW)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .prime     (prime),
        .no_factor (no_factor),
        .last      (last)
    );

    dpf_checker #(
        .VALUE_WIDTH (VW)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .prime        (prime),
        .no_factor    (no_factor),
        .last         (last),
        .fail_count   (fail_count),
        .pending      (pending),
        .values_seen  (values_seen),
        .results_seen (results_seen)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit is_prime_small(input longint unsigned n);
        longint unsigned d;
        if (n < 2)
            return 1'b0;
        for (d = 2; d * d <= n; d++)
            if (n % d == 0)
                return 1'b0;
        return 1'b1;
    endfunction

    // Random composite, now and then 0 or 1: small primes with exponents, sometimes
    // one larger prime; the trial count stays low
    function automatic logic [VW-1:0] rand_composite();
        longint unsigned acc;
        longint unsigned p;
        longint unsigned top_val;
        int              tries;
        top_val = (64'd1 << VW) - 1;
        acc     = 1;
        if ($urandom_range(99) < 5)
            return VW'($urandom_range(1, 0));
        if ($urandom_range(99) < 35)
        begin
            p = $urandom_range(20000, 1000);
            while (!is_prime_small(p))
                p++;
            acc = p;
        end
        tries = $urandom_range(20, 1);
        repeat (tries)
        begin
            p = small_primes[$urandom_range(small_primes.size() - 1)];
            repeat ($urandom_range(3, 1))
                if (acc * p <= top_val)
                    acc = acc * p;
        end
        return VW'(acc);
    endfunction

    // Offer one item, with random idle cycles ahead of it
    task automatic send_value(input logic [VW-1:0] v);
        while ($urandom_range(99) < tx_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Output back-pressure: random stalls plus one long hold on request
    always @(posedge clk)
    begin : rx_drive
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (choke_req && !choke_taken)
            begin
                hold_left   = CHOKE_CYCLES;
                choke_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= rx_gap_pct);
            end
        end
    end

    // Watchdog: too long without any item moving on either channel
    always @(posedge clk)
    begin : watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        value      = '0;
        choke_req  = 1'b0;
        tx_gap_pct = 15;
        rx_gap_pct = 56;

        for (int n = 2; n < 100; n++)
            if (is_prime_small(n))
                small_primes.insert(small_primes.size(), n);

        // Extremes, prime powers, the nine-prime product, big leftover primes
        edge_vals = '{32'd1, 32'd0, 32'd2, 32'd3, 32'd4, 32'd6, 32'd10, 32'd49,
                      32'd30030, 32'd223092870, 32'h8000_0000, 32'd3486784401,
                      32'd1042441, 32'd19946, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                      32'h5555_5555};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Sender idles lightly, receiver heavily
        foreach (edge_vals[i])
            send_value(edge_vals[i]);
        repeat (25)
            send_value(rand_composite());

        // Sender idles heavily, receiver lightly
        tx_gap_pct = 56;
        rx_gap_pct <= 15;
        repeat (28)
            send_value(rand_composite());

        // No idling; output held off while cheap items wait at the input
        tx_gap_pct = 0;
        rx_gap_pct <= 0;
        choke_req  <= 1'b1;
        repeat (12)
            send_value($urandom_range(300, 2));
        repeat (20)
            send_value(rand_composite());
        in_valid <= 1'b0;

        // Drain what is still owed, then settle
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d values factored, %0d results checked, %0d mismatches",
                 values_seen, results_seen, fail_count);
        $display("summary: edge and random values, three idle mixes, one %0d-cycle hold",
                 CHOKE_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
